/* design/stb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the software timer bank
// Slot status codes, slot record layout and item function codes.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ST_RELOAD  = 2'd0,
        ST_TIMING  = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_slot;

    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam t_slot SLOT_RESET = '{status: ST_RELOAD, count: '0};

endpackage

/* design/stb_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_mem: slot memory
// One write port, one read port with registered read data. Per-entry valid
// flags make unwritten entries read as the reset slot value.
// ----------------------------------------------------------------------------
module stb_mem
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output t_slot             o_rd_data,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  t_slot             i_wr_data
);

    t_slot                 r_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_vld;
    t_slot                 r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : SLOT_RESET;

endmodule

/* design/stb_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_seq: item sequencer
// Accepts an item, reads the addressed slot (or sweeps all slots for a
// tick), applies the poll or tick update, writes it back and hands the
// result on. A poll of an out-of-range index skips straight to the result.
// ----------------------------------------------------------------------------
module stb_seq
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [3:0]          i_timer_index,
    input  logic [COUNT_W-1:0]  i_reload_time,
    input  logic                i_auto_reload,
    output logic                o_rd_en,
    output logic [IDX_W-1:0]    o_rd_addr,
    input  t_slot               i_rd_data,
    output logic                o_wr_en,
    output logic [IDX_W-1:0]    o_wr_addr,
    output t_slot               o_wr_data,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic                o_res_expired
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POLL = 4'b0010,
        S_TICK = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_res, n_res;
    logic [COUNT_W-1:0]   r_reload;
    logic                 r_auto;

    logic                 accept;
    logic                 in_range;
    logic [IDX_W+3:0]     idx_wide;
    logic [IDX_W-1:0]     in_idx;
    t_slot                poll_slot;
    logic                 poll_exp;
    t_slot                tick_slot;

    assign idx_wide = {{IDX_W{1'b0}}, i_timer_index};
    assign in_idx   = idx_wide[IDX_W-1:0];
    assign in_range = (32'(i_timer_index) < 32'(NUM_TIMERS));
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    always_comb begin
        poll_slot = i_rd_data;
        poll_exp  = 1'b0;
        unique case (i_rd_data.status)
            ST_RELOAD: begin
                poll_slot.count  = r_reload;
                poll_slot.status = ST_TIMING;
            end
            ST_TIMING: begin
                if (i_rd_data.count == '0) begin
                    poll_exp = 1'b1;
                    if (r_auto) begin
                        poll_slot.count = r_reload;
                    end else begin
                        poll_slot.status = ST_TIMEOUT;
                    end
                end
            end
            ST_TIMEOUT: begin
                if (r_auto) begin
                    poll_slot.count  = r_reload;
                    poll_slot.status = ST_TIMING;
                end else begin
                    poll_exp = 1'b1;
                end
            end
            ST_UNKNOWN: begin
                if (r_auto) begin
                    poll_slot.count  = r_reload;
                    poll_slot.status = ST_TIMING;
                end else begin
                    poll_slot.status = ST_RELOAD;
                end
            end
        endcase
    end

    always_comb begin
        tick_slot = i_rd_data;
        if (i_rd_data.status == ST_TIMING && i_rd_data.count != '0) begin
            tick_slot.count = i_rd_data.count - COUNT_W'(1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = tick_slot;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = 1'b0;
                    if (i_func == FUNC_TICK) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = S_TICK;
                    end else if (in_range) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = in_idx;
                        n_idx     = in_idx;
                        n_state   = S_POLL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_POLL: begin
                o_wr_en   = 1'b1;
                o_wr_data = poll_slot;
                n_res     = poll_exp;
                n_state   = S_EMIT;
            end
            S_TICK: begin
                o_wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_EMIT;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + IDX_W'(1);
                    n_idx     = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_reload <= i_reload_time;
            r_auto   <= i_auto_reload;
        end
    end

    assign o_res_valid   = (r_state == S_EMIT);
    assign o_res_expired = r_res;

endmodule

/* design/software_timer_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank: bank of auto-reload / one-shot software timers
// A poll runs from transfer in to result ready through accept with slot
// read, read-modify-write and result handoff. A tick sweeps the slot
// memory one slot per cycle through its one read port and one write port.
// One item is in work at a time; the output register holds a finished
// result while the next item is accepted.
// ----------------------------------------------------------------------------
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [3:0]          i_timer_index,
    input  logic [COUNT_W-1:0]  i_reload_time,
    input  logic                i_auto_reload,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_expired
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_slot            rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;
    logic             res_valid;
    logic             res_ready;
    logic             res_expired;

    logic             r_o_valid;
    logic             r_o_expired;

    stb_seq #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_timer_index (i_timer_index),
        .i_reload_time (i_reload_time),
        .i_auto_reload (i_auto_reload),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res_expired (res_expired)
    );

    stb_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_o_expired <= res_expired;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_expired = r_o_expired;

endmodule

/* sim/software_timer_bank_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank_tb: self-checking bench for the software timer bank
// Drives poll and tick items through the valid/ready input channel with random
// gaps, bursts and a long output hold-off that backs up the block. A local
// model of the sixteen slots predicts the expired flag of every transfer in,
// and the monitor checks each transfer out against the oldest prediction.
// ----------------------------------------------------------------------------
module software_timer_bank_tb;
    import stb_pkg::*;

    localparam int N_SLOTS     = 16;
    localparam int N_RANDOM    = 1080;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                func;
        logic [3:0]          idx;
        logic [COUNT_W-1:0]  reload;
        logic                auto_rl;
    } t_timer_item;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [3:0]          i_timer_index;
    logic [COUNT_W-1:0]  i_reload_time;
    logic                i_auto_reload;
    logic                o_valid;
    logic                i_ready;
    logic                o_expired;

    t_timer_item         item_q[$];
    logic                expired_q[$];
    t_status             slot_state[N_SLOTS];
    logic [COUNT_W-1:0]  slot_count[N_SLOTS];

    int  total_items;
    int  items_in;
    int  results_out;
    int  polls_seen;
    int  ticks_seen;
    int  expiries_seen;
    int  err_count;
    int  send_gap;
    int  rcv_wait;
    int  hold_left;
    int  holds_done;
    bit  in_burst;
    bit  out_burst;
    bit  in_xfer;
    bit  out_xfer;
    t_timer_item cur_item;

    software_timer_bank #(
        .NUM_TIMERS (N_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_timer_index  (i_timer_index),
        .i_reload_time  (i_reload_time),
        .i_auto_reload  (i_auto_reload),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_expired      (o_expired)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic step_timers(input t_timer_item it);
        logic fired;
        fired = 1'b0;
        if (it.func == FUNC_TICK) begin
            ticks_seen++;
            for (int s = 0; s < N_SLOTS; s++) begin
                if (slot_state[s] == ST_TIMING && slot_count[s] != '0) begin
                    slot_count[s] = slot_count[s] - 1'b1;
                end
            end
        end else if (int'(it.idx) < N_SLOTS) begin
            polls_seen++;
            case (slot_state[it.idx])
                ST_RELOAD: begin
                    slot_count[it.idx] = it.reload;
                    slot_state[it.idx] = ST_TIMING;
                end
                ST_TIMING: begin
                    if (slot_count[it.idx] == '0) begin
                        fired = 1'b1;
                        if (it.auto_rl) begin
                            slot_count[it.idx] = it.reload;
                        end else begin
                            slot_state[it.idx] = ST_TIMEOUT;
                        end
                    end
                end
                ST_TIMEOUT: begin
                    if (it.auto_rl) begin
                        slot_count[it.idx] = it.reload;
                        slot_state[it.idx] = ST_TIMING;
                    end else begin
                        fired = 1'b1;
                    end
                end
                default: begin
                    if (it.auto_rl) begin
                        slot_count[it.idx] = it.reload;
                        slot_state[it.idx] = ST_TIMING;
                    end else begin
                        slot_state[it.idx] = ST_RELOAD;
                    end
                end
            endcase
        end else begin
            polls_seen++;
        end
        return fired;
    endfunction

    task automatic add_item(input logic func, input logic [3:0] idx,
                            input logic [COUNT_W-1:0] reload, input logic auto_rl);
        t_timer_item it;
        it.func    = func;
        it.idx     = idx;
        it.reload  = reload;
        it.auto_rl = auto_rl;
        item_q.push_back(it);
    endtask

    task automatic report_error(input string what, input logic want, input logic got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s (result %0d, expired expected %b got %b)",
                     $realtime, what, results_out, want, got);
        end
    endtask

    // driver: hold the payload until transfer, then wait the drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_xfer) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                cur_item = item_q.pop_front();
                i_func        <= cur_item.func;
                i_timer_index <= cur_item.idx;
                i_reload_time <= cur_item.reload;
                i_auto_reload <= cur_item.auto_rl;
                i_valid       <= 1'b1;
                send_gap = in_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long output hold-off, twice per run
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && items_in >= (holds_done + 1) * 350) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // receiver: stall a drawn number of cycles after each transfer out
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (out_xfer) begin
                rcv_wait = out_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor: check the output before predicting this edge's input
    always @(posedge i_clk) begin
        t_timer_item it;
        logic want;
        in_xfer  <= i_rst_n && i_valid && o_ready;
        out_xfer <= i_rst_n && o_valid && i_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (o_expired === 1'b1) expiries_seen++;
                if (expired_q.size() == 0) begin
                    report_error("result with no expectation waiting", 1'bx, o_expired);
                end else begin
                    want = expired_q.pop_front();
                    if (o_expired !== want) report_error("expired mismatch", want, o_expired);
                end
                results_out++;
            end
            if (i_valid && o_ready) begin
                it.func    = i_func;
                it.idx     = i_timer_index;
                it.reload  = i_reload_time;
                it.auto_rl = i_auto_reload;
                expired_q.push_back(step_timers(it));
                items_in++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d items in, %0d results out",
                 items_in, total_items, results_out);
        $display("software_timer_bank_tb failed");
        $finish;
    end

    initial begin
        logic [COUNT_W-1:0] rl;
        int pick;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_func        = FUNC_POLL;
        i_timer_index = '0;
        i_reload_time = '0;
        i_auto_reload = 1'b0;
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_state[s] = ST_RELOAD;
            slot_count[s] = '0;
        end

        // arm, expire in auto and one-shot, stay timed out, re-arm
        add_item(FUNC_POLL, 4'd0, 32'd0, 1'b1);
        add_item(FUNC_POLL, 4'd0, 32'd1, 1'b1);
        add_item(FUNC_POLL, 4'd0, 32'd0, 1'b0);
        add_item(FUNC_TICK, 4'd9, 32'h0000_0000, 1'b0);
        add_item(FUNC_POLL, 4'd0, 32'd5, 1'b0);
        add_item(FUNC_POLL, 4'd0, 32'd5, 1'b0);
        add_item(FUNC_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1);
        add_item(FUNC_POLL, 4'd0, 32'd2, 1'b1);
        add_item(FUNC_POLL, 4'd15, 32'hFFFF_FFFF, 1'b1);
        add_item(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_item(FUNC_POLL, 4'd15, 32'd0, 1'b0);
        add_item(FUNC_POLL, 4'd5, 32'h5555_5555, 1'b0);
        add_item(FUNC_POLL, 4'd10, 32'hAAAA_AAAA, 1'b1);
        add_item(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_item(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_item(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_item(FUNC_POLL, 4'd0, 32'd0, 1'b1);
        add_item(FUNC_POLL, 4'd0, 32'd3, 1'b1);
        add_item(FUNC_POLL, 4'd3, 32'd0, 1'b0);
        add_item(FUNC_POLL, 4'd3, 32'd0, 1'b0);
        add_item(FUNC_POLL, 4'd3, 32'd0, 1'b1);
        add_item(FUNC_TICK, 4'd7, 32'h1234_5678, 1'b1);

        // mostly short reloads so expiries come often
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 4) begin
                add_item(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom(),
                         1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 16) rl = $urandom_range(0, 4);
                else if (pick < 19) rl = $urandom();
                else rl = 32'hFFFF_FFFF;
                add_item(FUNC_POLL, 4'($urandom_range(0, 15)), rl,
                         1'($urandom_range(0, 1)));
            end
        end
        total_items = item_q.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (items_in < total_items) @(posedge i_clk);
        while (expired_q.size() != 0) @(posedge i_clk);
        repeat (N_SLOTS + 8) @(posedge i_clk);

        $display("covered %0d items: %0d polls, %0d ticks, %0d output hold-offs",
                 items_in, polls_seen, ticks_seen, holds_done);
        $display("checked %0d results, %0d expiries reported, %0d errors",
                 results_out, expiries_seen, err_count);
        if (err_count == 0) begin
            $display("software_timer_bank_tb passed");
        end else begin
            $display("software_timer_bank_tb failed");
        end
        $finish;
    end

endmodule
